// ===== design/sird_pkg.sv =====
// Shared types, constants and helpers for the signed integer to radix digits block.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package sird_pkg;

    localparam int VALUE_W    = 32;
    localparam int CHAR_W     = 8;
    localparam int ALPHA_N    = 16;
    localparam int ALPHA_IW   = 4;
    localparam int RADIX_W    = 5;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int DIV_STEPS  = 8;
    localparam int DIV_CYC    = VALUE_W / DIV_STEPS;
    localparam int DIV_PH_W   = $clog2(DIV_CYC);
    localparam int DIG_CNT_W  = $clog2(VALUE_W) + 1;
    localparam int DIG_IDX_W  = $clog2(VALUE_W);

    localparam logic [CFG_IDX_W-1:0] CFG_DIGITS_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIGITS_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIX       = 2'd2;

    localparam logic [CHAR_W-1:0]  CH_NUL    = 8'h00;
    localparam logic [CHAR_W-1:0]  CH_PLUS   = 8'h2B;
    localparam logic [CHAR_W-1:0]  CH_MINUS  = 8'h2D;
    localparam logic [RADIX_W-1:0] MIN_RADIX = 5'd2;

    typedef struct packed {
        logic done;
        logic ok;
    } t_chk_sts;

    typedef struct packed {
        logic dig_valid;
        logic final_dig;
    } t_div_sts;

    function automatic logic [CHAR_W-1:0] alpha_char(
        input logic [CFG_DATA_W-1:0] lo,
        input logic [CFG_DATA_W-1:0] hi,
        input logic [ALPHA_IW-1:0]   idx
    );
        logic [CFG_DATA_W-1:0] word;
        word = idx[ALPHA_IW-1] ? hi : lo;
        return word[idx[ALPHA_IW-2:0]*CHAR_W +: CHAR_W];
    endfunction

endpackage

`default_nettype wire

// ===== design/sird_alpha_chk.sv =====
// Alphabet checker: walks the characters in use one per cycle, rejects NUL, +, -
// and compares each against all later ones in parallel. Depends on sird_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sird_alpha_chk #(
    parameter int MAX_RADIX = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic [sird_pkg::CFG_DATA_W-1:0]   i_digits_low,
    input  wire logic [sird_pkg::CFG_DATA_W-1:0]   i_digits_high,
    input  wire logic [sird_pkg::RADIX_W-1:0]      i_radix,
    output sird_pkg::t_chk_sts                     o_sts
);

    logic                            r_busy, n_busy;
    logic [sird_pkg::ALPHA_IW-1:0]   r_idx, n_idx;
    logic [sird_pkg::CHAR_W-1:0]     c;
    logic                            range_bad;
    logic                            row_bad;

    assign c = sird_pkg::alpha_char(i_digits_low, i_digits_high, r_idx);
    assign range_bad = (i_radix < sird_pkg::MIN_RADIX) ||
                       (i_radix > sird_pkg::RADIX_W'(MAX_RADIX));

    always_comb begin
        row_bad = (c == sird_pkg::CH_NUL) || (c == sird_pkg::CH_PLUS) ||
                  (c == sird_pkg::CH_MINUS);
        for (int b = 0; b < sird_pkg::ALPHA_N; b++) begin
            if ((sird_pkg::ALPHA_IW'(b) > r_idx) && (sird_pkg::RADIX_W'(b) < i_radix) &&
                (sird_pkg::alpha_char(i_digits_low, i_digits_high,
                                      sird_pkg::ALPHA_IW'(b)) == c)) begin
                row_bad = 1'b1;
            end
        end
    end

    always_comb begin
        n_busy     = r_busy;
        n_idx      = r_idx;
        o_sts.done = 1'b0;
        o_sts.ok   = 1'b0;
        if (i_start) begin
            n_busy = 1'b1;
            n_idx  = '0;
        end else if (r_busy) begin
            if (range_bad || row_bad) begin
                o_sts.done = 1'b1;
                n_busy     = 1'b0;
            end else if ({1'b0, r_idx} == i_radix - sird_pkg::RADIX_W'(1)) begin
                o_sts.done = 1'b1;
                o_sts.ok   = 1'b1;
                n_busy     = 1'b0;
            end else begin
                n_idx = r_idx + sird_pkg::ALPHA_IW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
    end

endmodule

`default_nettype wire

// ===== design/sird_divider.sv =====
// Radix divider: restoring division of the magnitude by the radix, several
// quotient bits per cycle, one remainder digit per pass. Depends on sird_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sird_divider #(
    parameter int MAX_RADIX = 16,
    parameter int DW        = $clog2(MAX_RADIX)
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic [sird_pkg::VALUE_W-1:0]    i_mag,
    input  wire logic [sird_pkg::RADIX_W-1:0]    i_radix,
    output sird_pkg::t_div_sts                   o_sts,
    output logic      [DW-1:0]                   o_digit
);

    logic                              r_busy, n_busy;
    logic [sird_pkg::VALUE_W-1:0]      r_quo, n_quo;
    logic [DW-1:0]                     r_rem, n_rem;
    logic [sird_pkg::DIV_PH_W-1:0]     r_phase, n_phase;
    logic [sird_pkg::DIG_CNT_W-1:0]    r_ndig, n_ndig;
    logic [sird_pkg::VALUE_W-1:0]      t_q;
    logic [DW-1:0]                     t_r;
    logic [DW:0]                       t_r5;
    logic                              t_qb;
    logic                              last_ph;

    always_comb begin
        t_q = r_quo;
        t_r = r_rem;
        for (int k = 0; k < sird_pkg::DIV_STEPS; k++) begin
            t_r5 = {t_r, t_q[sird_pkg::VALUE_W-1]};
            t_qb = (sird_pkg::RADIX_W'(t_r5) >= i_radix);
            if (t_qb) begin
                t_r5 = t_r5 - (DW+1)'(i_radix);
            end
            t_r = t_r5[DW-1:0];
            t_q = {t_q[sird_pkg::VALUE_W-2:0], t_qb};
        end
    end

    assign last_ph = (r_phase == sird_pkg::DIV_PH_W'(sird_pkg::DIV_CYC - 1));
    assign o_digit = t_r;

    always_comb begin
        n_busy          = r_busy;
        n_quo           = r_quo;
        n_rem           = r_rem;
        n_phase         = r_phase;
        n_ndig          = r_ndig;
        o_sts.dig_valid = 1'b0;
        o_sts.final_dig = 1'b0;
        if (i_start) begin
            n_busy  = 1'b1;
            n_quo   = i_mag;
            n_rem   = '0;
            n_phase = '0;
            n_ndig  = '0;
        end else if (r_busy) begin
            n_quo   = t_q;
            n_rem   = t_r;
            n_phase = r_phase + sird_pkg::DIV_PH_W'(1);
            if (last_ph) begin
                o_sts.dig_valid = 1'b1;
                o_sts.final_dig = (t_q == '0) ||
                                  (r_ndig == sird_pkg::DIG_CNT_W'(sird_pkg::VALUE_W - 1));
                n_rem  = '0;
                n_ndig = r_ndig + sird_pkg::DIG_CNT_W'(1);
                n_busy = !o_sts.final_dig;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= '0;
            r_ndig  <= '0;
        end else begin
            r_busy  <= n_busy;
            r_phase <= n_phase;
            r_ndig  <= n_ndig;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
    end

endmodule

`default_nettype wire

// ===== design/signed_integer_to_radix_digits_top.sv =====
// Flow: an accepted value goes through the alphabet check, then the divider yields
// the digits (8 quotient bits a cycle over 32 bits), then one char per cycle unless
// the output stalls. One value at a time: a new value is accepted only when idle.
// Reset: synchronous active-low; clears config to 0, empties the output register.
// Top level: config registers, sequencer, digit buffer, output register.
// Depends on sird_pkg, sird_alpha_chk, sird_divider.
`timescale 1ns / 1ps
`default_nettype none

module signed_integer_to_radix_digits_top #(
    parameter int MAX_RADIX = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [sird_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [sird_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic signed [sird_pkg::VALUE_W-1:0] i_value,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic      [sird_pkg::CHAR_W-1:0]         o_character,
    output logic                                     o_last
);

    localparam int DW = $clog2(MAX_RADIX);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_DIV   = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [sird_pkg::CFG_DATA_W-1:0]  r_digits_low, r_digits_high;
    logic [sird_pkg::RADIX_W-1:0]     r_radix;
    logic [1:0]                       r_state, n_state;
    logic                             r_neg, n_neg;
    logic [sird_pkg::VALUE_W-1:0]     r_mag, n_mag;
    logic [sird_pkg::DIG_CNT_W-1:0]   r_cnt, n_cnt;
    logic                             r_sign, n_sign;
    logic                             r_out_valid, n_out_valid;
    logic [sird_pkg::CHAR_W-1:0]      r_char, n_char;
    logic                             r_last, n_last;
    logic [DW-1:0]                    r_dbuf [sird_pkg::VALUE_W];
    logic                             dbuf_we;
    logic [DW-1:0]                    rd_digit;
    logic                             in_acc;
    logic                             out_free;
    logic                             div_start;
    logic [DW-1:0]                    div_digit;
    sird_pkg::t_chk_sts               chk_sts;
    sird_pkg::t_div_sts               div_sts;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_character = r_char;
    assign o_last      = r_last;

    assign in_acc    = i_in_valid && o_in_ready;
    assign out_free  = !r_out_valid || i_out_ready;
    assign div_start = (r_state == S_CHECK) && chk_sts.done && chk_sts.ok;
    assign dbuf_we   = (r_state == S_DIV) && div_sts.dig_valid;
    assign rd_digit  = r_dbuf[sird_pkg::DIG_IDX_W'(r_cnt - sird_pkg::DIG_CNT_W'(1))];

    sird_alpha_chk #(
        .MAX_RADIX (MAX_RADIX)
    ) u_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (in_acc),
        .i_digits_low  (r_digits_low),
        .i_digits_high (r_digits_high),
        .i_radix       (r_radix),
        .o_sts         (chk_sts)
    );

    sird_divider #(
        .MAX_RADIX (MAX_RADIX),
        .DW        (DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_mag   (r_mag),
        .i_radix (r_radix),
        .o_sts   (div_sts),
        .o_digit (div_digit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digits_low  <= '0;
            r_digits_high <= '0;
            r_radix       <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                sird_pkg::CFG_DIGITS_LOW:  r_digits_low  <= i_cfg_data;
                sird_pkg::CFG_DIGITS_HIGH: r_digits_high <= i_cfg_data;
                sird_pkg::CFG_RADIX:       r_radix <= i_cfg_data[sird_pkg::RADIX_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state     = r_state;
        n_neg       = r_neg;
        n_mag       = r_mag;
        n_cnt       = r_cnt;
        n_sign      = r_sign;
        n_out_valid = r_out_valid && !i_out_ready;
        n_char      = r_char;
        n_last      = r_last;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_neg   = i_value[sird_pkg::VALUE_W-1];
                    n_mag   = i_value[sird_pkg::VALUE_W-1] ?
                              (sird_pkg::VALUE_W'(0) - $unsigned(i_value)) : $unsigned(i_value);
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (chk_sts.done) begin
                    n_cnt   = '0;
                    n_state = chk_sts.ok ? S_DIV : S_IDLE;
                end
            end
            S_DIV: begin
                if (div_sts.dig_valid) begin
                    n_cnt = r_cnt + sird_pkg::DIG_CNT_W'(1);
                    if (div_sts.final_dig) begin
                        n_sign  = r_neg;
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (r_sign) begin
                        n_char = sird_pkg::CH_MINUS;
                        n_last = 1'b0;
                        n_sign = 1'b0;
                    end else begin
                        n_char = sird_pkg::alpha_char(r_digits_low, r_digits_high,
                                                      sird_pkg::ALPHA_IW'(rd_digit));
                        n_last = (r_cnt == sird_pkg::DIG_CNT_W'(1));
                        n_cnt  = r_cnt - sird_pkg::DIG_CNT_W'(1);
                        if (n_last) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_sign      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_sign      <= n_sign;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg  <= n_neg;
        r_mag  <= n_mag;
        r_char <= n_char;
        r_last <= n_last;
        if (dbuf_we) begin
            r_dbuf[sird_pkg::DIG_IDX_W'(r_cnt)] <= div_digit;
        end
    end

    a_emit_has_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_cnt != '0))
        else $error("emit state with empty digit buffer");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= sird_pkg::DIG_CNT_W'(sird_pkg::VALUE_W))
        else $error("digit count beyond buffer depth");

    a_div_only_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_sts.dig_valid |-> (r_state == S_DIV))
        else $error("divider digit outside divide phase");

    a_chk_only_in_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        chk_sts.done |-> (r_state == S_CHECK))
        else $error("checker done outside check phase");

    a_accept_starts_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_CHECK))
        else $error("accepted word did not start alphabet check");

endmodule

`default_nettype wire
